/* rtl/core/rtb_pkg.sv */
// Shared types, widths and codes for the repeating timer bank.
package rtb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int LEN_W  = 31;
    localparam int REP_W  = 17;
    localparam int TIME_W = 32;

    // repeat count of -1: the slot never runs out
    localparam logic [REP_W-1:0] REP_FOREVER = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_DISARM = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // per-field write enables of the slot memory
    typedef struct packed {
        logic start;
        logic period;
        logic reps;
    } t_mem_we;

    // one firing word handed to the output register
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic              final_fire;
        logic              last;
    } t_push;

endpackage

/* rtl/core/repeating_timer_bank.sv */
// Repeating timer bank top level: command channel, slot memory, scan control and output register.
// Arm, disarm and disarm-all do not raise o_stall; the next word is accepted in the following cycle.
// A tick holds o_stall while the scan and the flush run. The scan reads one slot per cycle from
// the single-read-port slot memory while the output register keeps up, and then the flush runs.
// A held firing word that cannot enter the output register stalls the scan or the flush.
// Words leave in slot order, each held until the tick's next firing or the flush (last set).
// Reset (i_rst_n low, synchronous) clears all armed and pending flags; memory is not cleared.
module repeating_timer_bank import rtb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command words
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SLOT_W-1:0] i_timer_slot,
    input  logic [LEN_W-1:0]  i_length_ms,
    input  logic [REP_W-1:0]  i_repeat_count,
    input  logic [TIME_W-1:0] i_now_ms,
    // firing words
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SLOT_W-1:0] o_fired_slot,
    output logic              o_final_fire,
    output logic              o_last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [TIME_W-1:0] rd_start;
    logic [LEN_W-1:0]  rd_period;
    logic [REP_W-1:0]  rd_reps;
    logic [IW-1:0]     wr_addr;
    t_mem_we           we;
    logic [TIME_W-1:0] wd_start;
    logic [LEN_W-1:0]  wd_period;
    logic [REP_W-1:0]  wd_reps;
    t_push             push;
    logic              out_free;

    logic              r_o_valid;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_final;
    logic              r_o_last;

    // Per-slot start time, period and repeats left. Each tick reads slot i while
    // writing back slot i-1, so the read and write never meet on one entry and
    // no forwarding is needed; arms only happen between scans.
    rtb_slot_mem #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_start  (rd_start),
        .o_rd_period (rd_period),
        .o_rd_reps   (rd_reps),
        .i_wr_addr   (wr_addr),
        .i_we        (we),
        .i_wd_start  (wd_start),
        .i_wd_period (wd_period),
        .i_wd_reps   (wd_reps)
    );

    // Command decode, armed/pending flags in flops, and the scan. The scan keeps
    // one firing in hand so that the final one of the tick can carry last.
    rtb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_timer_slot   (i_timer_slot),
        .i_length_ms    (i_length_ms),
        .i_repeat_count (i_repeat_count),
        .i_now_ms       (i_now_ms),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_start     (rd_start),
        .i_rd_period    (rd_period),
        .i_rd_reps      (rd_reps),
        .o_wr_addr      (wr_addr),
        .o_we           (we),
        .o_wd_start     (wd_start),
        .o_wd_period    (wd_period),
        .o_wd_reps      (wd_reps),
        .o_push         (push),
        .i_out_free     (out_free)
    );

    // Output register: free when empty or when its word leaves this cycle.
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (push.valid) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_o_slot  <= push.slot;
            r_o_final <= push.final_fire;
            r_o_last  <= push.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_fired_slot = r_o_slot;
    assign o_final_fire = r_o_final;
    assign o_last       = r_o_last;

endmodule

/* rtl/core/rtb_slot_mem.sv */
// Slot memory: start time, period and repeats left, one write and one registered read port.
module rtb_slot_mem import rtb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [TIME_W-1:0] o_rd_start,
    output logic [LEN_W-1:0]  o_rd_period,
    output logic [REP_W-1:0]  o_rd_reps,
    input  logic [IW-1:0]     i_wr_addr,
    input  t_mem_we           i_we,
    input  logic [TIME_W-1:0] i_wd_start,
    input  logic [LEN_W-1:0]  i_wd_period,
    input  logic [REP_W-1:0]  i_wd_reps
);

    logic [TIME_W-1:0] mem_start  [NUM_TIMERS];
    logic [LEN_W-1:0]  mem_period [NUM_TIMERS];
    logic [REP_W-1:0]  mem_reps   [NUM_TIMERS];

    logic [TIME_W-1:0] r_rd_start;
    logic [LEN_W-1:0]  r_rd_period;
    logic [REP_W-1:0]  r_rd_reps;

    always_ff @(posedge i_clk) begin
        if (i_we.start) begin
            mem_start[i_wr_addr] <= i_wd_start;
        end
        if (i_we.period) begin
            mem_period[i_wr_addr] <= i_wd_period;
        end
        if (i_we.reps) begin
            mem_reps[i_wr_addr] <= i_wd_reps;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_start  <= mem_start[i_rd_addr];
            r_rd_period <= mem_period[i_rd_addr];
            r_rd_reps   <= mem_reps[i_rd_addr];
        end
    end

    assign o_rd_start  = r_rd_start;
    assign o_rd_period = r_rd_period;
    assign o_rd_reps   = r_rd_reps;

endmodule

/* rtl/core/rtb_ctrl.sv */
// Command decode, slot flags and the read-modify-write scan over the slot memory.
module rtb_ctrl import rtb_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
    localparam int CW = $clog2(NUM_TIMERS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SLOT_W-1:0] i_timer_slot,
    input  logic [LEN_W-1:0]  i_length_ms,
    input  logic [REP_W-1:0]  i_repeat_count,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_addr,
    input  logic [TIME_W-1:0] i_rd_start,
    input  logic [LEN_W-1:0]  i_rd_period,
    input  logic [REP_W-1:0]  i_rd_reps,
    output logic [IW-1:0]     o_wr_addr,
    output t_mem_we           o_we,
    output logic [TIME_W-1:0] o_wd_start,
    output logic [LEN_W-1:0]  o_wd_period,
    output logic [REP_W-1:0]  o_wd_reps,
    output t_push             o_push,
    input  logic              i_out_free
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                r_state;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] r_started;
    logic [TIME_W-1:0]     r_now;
    logic [CW-1:0]         r_rd_idx;
    logic                  r_ev_valid;
    logic [IW-1:0]         r_ev_idx;
    logic                  r_hold_valid;
    logic [SLOT_W-1:0]     r_hold_slot;
    logic                  r_hold_final;

    logic              accept;
    t_cmd              cmd;
    logic              slot_ok;
    logic [IW-1:0]     slot_idx;
    logic              rd_more;
    logic              ev_armed;
    logic              ev_started;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic              fire;
    logic              rep_forever;
    logic              rep_dec;
    logic              ev_final;
    logic              ev_go;
    logic              adv;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign cmd      = t_cmd'(i_cmd);
    assign slot_ok  = (32'(i_timer_slot) < 32'(NUM_TIMERS));
    assign slot_idx = IW'(i_timer_slot);

    // evaluate stage: memory word of r_ev_idx is on the read port
    assign rd_more     = (r_rd_idx != CW'(NUM_TIMERS));
    assign ev_armed    = r_armed[r_ev_idx];
    assign ev_started  = r_started[r_ev_idx];
    assign start_eff   = ev_started ? i_rd_start : r_now;
    assign elapsed     = r_now - start_eff;
    assign fire        = r_ev_valid && ev_armed && (elapsed >= {1'b0, i_rd_period});
    assign rep_forever = (i_rd_reps == REP_FOREVER);
    assign rep_dec     = (i_rd_reps != '0) && !i_rd_reps[REP_W-1];
    assign ev_final    = !rep_forever && !rep_dec;
    // a second firing with one already held needs the output register free
    assign ev_go       = !(fire && r_hold_valid && !i_out_free);
    assign adv         = !r_ev_valid || ev_go;

    assign o_rd_en   = (r_state == S_SCAN) && adv && rd_more;
    assign o_rd_addr = r_rd_idx[IW-1:0];

    // write port: arm writes length and repeats, scan writes start and repeats
    always_comb begin
        o_wr_addr   = r_ev_idx;
        o_we        = '0;
        o_wd_start  = r_now;
        o_wd_period = i_length_ms;
        o_wd_reps   = i_rd_reps - REP_W'(1);
        if (r_state == S_SCAN) begin
            o_we.start = r_ev_valid && ev_go && ev_armed && (!ev_started || fire);
            o_we.reps  = r_ev_valid && ev_go && fire && rep_dec;
        end else if (accept && (cmd == CMD_ARM) && slot_ok) begin
            o_wr_addr   = slot_idx;
            o_we.period = 1'b1;
            o_we.reps   = 1'b1;
            o_wd_reps   = i_repeat_count;
        end
    end

    always_comb begin
        o_push.valid      = 1'b0;
        o_push.slot       = r_hold_slot;
        o_push.final_fire = r_hold_final;
        o_push.last       = 1'b0;
        case (r_state)
            S_SCAN: begin
                o_push.valid = fire && r_hold_valid && ev_go;
            end
            S_FLUSH: begin
                o_push.valid = r_hold_valid && i_out_free;
                o_push.last  = 1'b1;
            end
            default: begin
                o_push.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= '0;
            r_started    <= '0;
            r_rd_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_ev_idx     <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (cmd)
                            CMD_TICK: begin
                                r_now    <= i_now_ms;
                                r_rd_idx <= '0;
                                r_state  <= S_SCAN;
                            end
                            CMD_ARM: begin
                                if (slot_ok) begin
                                    r_armed[slot_idx]   <= 1'b1;
                                    r_started[slot_idx] <= 1'b0;
                                end
                            end
                            CMD_DISARM: begin
                                if (slot_ok) begin
                                    r_armed[slot_idx]   <= 1'b0;
                                    r_started[slot_idx] <= 1'b0;
                                end
                            end
                            default: begin
                                r_armed   <= '0;
                                r_started <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_ev_valid && ev_go && ev_armed) begin
                        if (fire && ev_final) begin
                            r_armed[r_ev_idx]   <= 1'b0;
                            r_started[r_ev_idx] <= 1'b0;
                        end else begin
                            r_started[r_ev_idx] <= 1'b1;
                        end
                    end
                    if (fire && ev_go) begin
                        r_hold_valid <= 1'b1;
                        r_hold_slot  <= SLOT_W'(r_ev_idx);
                        r_hold_final <= ev_final;
                    end
                    if (adv) begin
                        if (rd_more) begin
                            r_ev_valid <= 1'b1;
                            r_ev_idx   <= r_rd_idx[IW-1:0];
                            r_rd_idx   <= r_rd_idx + CW'(1);
                        end else begin
                            r_ev_valid <= 1'b0;
                            r_state    <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_valid) begin
                        r_state <= S_IDLE;
                    end else if (i_out_free) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a word leaves for the output register only when that register can take it
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_free)
        else $error("firing pushed while output register busy");

    // a tick always ends with the held firing delivered
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held firing left behind after scan");

    // the evaluate stage only carries a slot during a scan
    a_ev_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_valid |-> (r_state == S_SCAN))
        else $error("evaluate stage active outside scan");

    // an accepted tick starts the scan at slot zero
    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == CMD_TICK)) |=> ((r_state == S_SCAN) && (r_rd_idx == '0)))
        else $error("tick did not start a scan");

    // the word pushed in the flush, which carries last, ends the tick
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && (r_state == S_FLUSH)) |=> (r_state == S_IDLE))
        else $error("flush did not return to idle");

endmodule
